>>> sv/cft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
package cft_pkg;

  // Default cap on fields per line (hardware limit).
  localparam int MaxFieldsDef = 64;

  // Configuration register map (word index) and reset value.
  localparam int RegFieldLimit   = 0;
  localparam int RegCount        = 1;
  localparam logic [6:0] FieldLimitReset = 7'd64;

  // Special characters.
  localparam logic [7:0] QuoteChar = 8'h22;
  localparam logic [7:0] CommaChar = 8'h2C;

  // Result queue depth; one item can push two results.
  localparam int FifoDepth = 4;

  // Request codes.
  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_EOL  = 1'b1
  } req_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_e;

  // One result transaction.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [5:0] field_number;
    logic [6:0] fields_in_row;
    logic       last;
  } result_t;

endpackage

>>> sv/csv_field_tokenizer.sv
// CSV field tokenizer: byte-wise line splitter with quoted-field handling.
//
// Usage
// - Input channel (in_valid_i / in_stall_o): one transaction per line byte
//   (req_type_i = 0, in_byte_i) or end-of-line marker (req_type_i = 1).
// - Output channel (out_valid_o / out_stall_i): content bytes, field ends and
//   one row end per end-of-line marker, with last_o on the final result that
//   an input transaction causes. An input transaction gives 0, 1 or 2 results.
// - APB port: register 0 (byte address 0) is field_limit, reset 64.
//   Write it only while the block is idle.
// Throughput: one input per cycle while in_stall_o is low. Every accepted input
//   updates the parse state at once; its results go to a 4-entry result queue
//   which drains one result per cycle while out_stall_i is low. Only the
//   end-of-line marker that closes an open field gives two results, so the
//   output port is the limit only then.
// Stall: in_stall_o rises when fewer than two queue slots are free, so a
//   stalled receiver backs up into the sender after a few transactions.
// Reset: queue empty, parse mode at field start, field count zero,
//   field_limit 64. No clearing pass is needed.
module csv_field_tokenizer #(
  parameter int MaxFields = cft_pkg::MaxFieldsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  in_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [5:0]  field_number_o,
  output logic [6:0]  fields_in_row_o,
  output logic        last_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The register is 7 bits, so no more than 127 fields can ever be open.
  localparam int LimMax = (MaxFields < 127) ? MaxFields : 127;
  localparam int CntW   = $clog2(LimMax + 1);
  localparam int PtrW   = $clog2(cft_pkg::FifoDepth);
  localparam int FillW  = $clog2(cft_pkg::FifoDepth + 1);

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_UNQ    = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_SKIP   = 3'd4,
    MODE_IGNORE = 3'd5
  } mode_e;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [6:0] field_limit_q;
  logic       cfg_wr;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'(cft_pkg::RegFieldLimit));
  assign cfg_wr  = psel & penable & pwrite & reg_sel;
  assign prdata  = reg_sel ? {25'd0, field_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_limit_q <= cft_pkg::FieldLimitReset;
    end else if (cfg_wr) begin
      field_limit_q <= pwdata[6:0];
    end
  end

  // ---------------------------------------------------------------------
  // Parser
  // ---------------------------------------------------------------------
  mode_e                 mode_q, mode_d;
  logic [CntW-1:0]       cnt_q, cnt_d, cnt_inc;
  logic                  accept;
  logic                  in_field;
  logic                  at_limit;
  logic [1:0]            n_res;
  cft_pkg::result_t      res0, res1;
  cft_pkg::result_t      r_content, r_fend, r_rowend_open, r_rowend_shut;
  logic [5:0]            fnum;

  logic [FillW-1:0]      fill_q;

  assign in_stall_o = (fill_q > FillW'(cft_pkg::FifoDepth - 2));
  assign accept     = in_valid_i & ~in_stall_o;

  assign in_field = (mode_q == MODE_UNQ) || (mode_q == MODE_QUOTED) ||
                    (mode_q == MODE_QSEEN) || (mode_q == MODE_SKIP);
  assign at_limit = (7'(cnt_q) >= field_limit_q) || (cnt_q >= CntW'(LimMax));
  assign cnt_inc  = cnt_q + CntW'(1);
  assign fnum     = 6'(7'(cnt_q));

  always_comb begin
    r_content               = '0;
    r_content.kind          = cft_pkg::KIND_CONTENT;
    r_content.out_byte      = in_byte_i;
    r_content.field_number  = fnum;
    r_content.last          = 1'b1;

    r_fend                  = '0;
    r_fend.kind             = cft_pkg::KIND_FIELD_END;
    r_fend.field_number     = fnum;
    r_fend.last             = 1'b1;

    // row end after closing the open field: count includes it
    r_rowend_open               = '0;
    r_rowend_open.kind          = cft_pkg::KIND_ROW_END;
    r_rowend_open.fields_in_row = 7'(cnt_inc);
    r_rowend_open.last          = 1'b1;

    r_rowend_shut               = '0;
    r_rowend_shut.kind          = cft_pkg::KIND_ROW_END;
    r_rowend_shut.fields_in_row = 7'(cnt_q);
    r_rowend_shut.last          = 1'b1;
  end

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    n_res  = 2'd0;
    res0   = r_content;
    res1   = r_rowend_open;

    if (req_type_i == cft_pkg::REQ_EOL) begin
      if (in_field) begin
        res0      = r_fend;
        res0.last = 1'b0;
        res1      = r_rowend_open;
        n_res     = 2'd2;
      end else begin
        res0  = r_rowend_shut;
        n_res = 2'd1;
      end
      mode_d = MODE_START;
      cnt_d  = '0;
    end else if (in_byte_i == 8'd0) begin
      // NUL terminates the line content
      if (in_field) begin
        res0  = r_fend;
        n_res = 2'd1;
        cnt_d = cnt_inc;
      end
      mode_d = MODE_IGNORE;
    end else begin
      case (mode_q)
        MODE_START: begin
          if (at_limit) begin
            mode_d = MODE_IGNORE;
          end else if (in_byte_i == cft_pkg::QuoteChar) begin
            mode_d = MODE_QUOTED;
          end else if (in_byte_i == cft_pkg::CommaChar) begin
            // empty field; stays at field start
            res0  = r_fend;
            n_res = 2'd1;
            cnt_d = cnt_inc;
          end else begin
            res0   = r_content;
            n_res  = 2'd1;
            mode_d = MODE_UNQ;
          end
        end
        MODE_UNQ: begin
          if (in_byte_i == cft_pkg::CommaChar) begin
            res0   = r_fend;
            n_res  = 2'd1;
            cnt_d  = cnt_inc;
            mode_d = MODE_START;
          end else begin
            res0  = r_content;
            n_res = 2'd1;
          end
        end
        MODE_QUOTED: begin
          if (in_byte_i == cft_pkg::QuoteChar) begin
            mode_d = MODE_QSEEN;
          end else begin
            res0  = r_content;
            n_res = 2'd1;
          end
        end
        MODE_QSEEN: begin
          if (in_byte_i == cft_pkg::QuoteChar) begin
            // doubled quote: one literal quote
            res0   = r_content;
            n_res  = 2'd1;
            mode_d = MODE_QUOTED;
          end else if (in_byte_i == cft_pkg::CommaChar) begin
            res0   = r_fend;
            n_res  = 2'd1;
            cnt_d  = cnt_inc;
            mode_d = MODE_START;
          end else begin
            mode_d = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (in_byte_i == cft_pkg::CommaChar) begin
            res0   = r_fend;
            n_res  = 2'd1;
            cnt_d  = cnt_inc;
            mode_d = MODE_START;
          end
        end
        default: begin
          // ignore rest of line
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  cft_pkg::result_t  fifo_q [cft_pkg::FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [1:0]        n_push;
  logic              pop;
  cft_pkg::result_t  head;

  assign n_push = accept ? n_res : 2'd0;
  assign head   = fifo_q[rd_ptr_q];
  assign pop    = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      fill_q   <= fill_q + FillW'(n_push) - FillW'(pop);
    end
  end

  assign out_valid_o     = (fill_q != '0);
  assign kind_o          = head.kind;
  assign out_byte_o      = head.out_byte;
  assign field_number_o  = head.field_number;
  assign fields_in_row_o = head.fields_in_row;
  assign last_o          = head.last;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(cft_pkg::FifoDepth))
    else $error("result queue overfilled");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(LimMax))
    else $error("field counter beyond limit cap");

  a_eol_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == cft_pkg::REQ_EOL) |=> (mode_q == MODE_START && cnt_q == '0))
    else $error("parser not restarted after end of line");

  a_rowend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && head.kind == cft_pkg::KIND_ROW_END) |-> head.last)
    else $error("row end without last");
`endif

endmodule
